FILE: hdl/bef_pkg.sv
// ----------------------------------------------------------------------------
// bef_pkg: shared types and constants for the band-pass envelope filter
// Holds the tap counts, the rounding bias, the sequencer state type and the
// coefficient tables of both FIR stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bef_pkg;

	localparam int BAND_TAPS   = 30;
	localparam int SMOOTH_TAPS = 33;
	localparam int DATA_W      = 16;
	localparam int COEF_W      = 16;
	localparam int ACC_W       = 32;
	localparam int IDX_W       = 6;
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = 32'sd16384;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAND,
		ST_BAND_DRAIN,
		ST_BAND_FIN,
		ST_SMOOTH,
		ST_SMOOTH_DRAIN,
		ST_SMOOTH_FIN
	} state_t;

	function automatic logic signed [COEF_W-1:0] band_coef(input logic [IDX_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		unique case (k)
			6'd0:  c = 16'sd228;
			6'd1:  c = 16'sd227;
			6'd2:  c = 16'sd200;
			6'd3:  c = 16'sd62;
			6'd4:  c = -16'sd268;
			6'd5:  c = -16'sd810;
			6'd6:  c = -16'sd1471;
			6'd7:  c = -16'sd2052;
			6'd8:  c = -16'sd2296;
			6'd9:  c = -16'sd1988;
			6'd10: c = -16'sd1051;
			6'd11: c = 16'sd395;
			6'd12: c = 16'sd2043;
			6'd13: c = 16'sd3479;
			6'd14: c = 16'sd4314;
			6'd15: c = 16'sd4314;
			6'd16: c = 16'sd3479;
			6'd17: c = 16'sd2043;
			6'd18: c = 16'sd395;
			6'd19: c = -16'sd1051;
			6'd20: c = -16'sd1988;
			6'd21: c = -16'sd2296;
			6'd22: c = -16'sd2052;
			6'd23: c = -16'sd1471;
			6'd24: c = -16'sd810;
			6'd25: c = -16'sd268;
			6'd26: c = 16'sd62;
			6'd27: c = 16'sd200;
			6'd28: c = 16'sd227;
			6'd29: c = 16'sd228;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] smooth_coef(input logic [IDX_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		unique case (k)
			6'd0:  c = 16'sd668;
			6'd1:  c = 16'sd356;
			6'd2:  c = 16'sd442;
			6'd3:  c = 16'sd536;
			6'd4:  c = 16'sd634;
			6'd5:  c = 16'sd736;
			6'd6:  c = 16'sd840;
			6'd7:  c = 16'sd944;
			6'd8:  c = 16'sd1044;
			6'd9:  c = 16'sd1139;
			6'd10: c = 16'sd1228;
			6'd11: c = 16'sd1306;
			6'd12: c = 16'sd1374;
			6'd13: c = 16'sd1428;
			6'd14: c = 16'sd1468;
			6'd15: c = 16'sd1492;
			6'd16: c = 16'sd1500;
			6'd17: c = 16'sd1492;
			6'd18: c = 16'sd1468;
			6'd19: c = 16'sd1428;
			6'd20: c = 16'sd1374;
			6'd21: c = 16'sd1306;
			6'd22: c = 16'sd1228;
			6'd23: c = 16'sd1139;
			6'd24: c = 16'sd1044;
			6'd25: c = 16'sd944;
			6'd26: c = 16'sd840;
			6'd27: c = 16'sd736;
			6'd28: c = 16'sd634;
			6'd29: c = 16'sd536;
			6'd30: c = 16'sd442;
			6'd31: c = 16'sd356;
			6'd32: c = 16'sd668;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/bandpass_envelope_filter_q15.sv
// ----------------------------------------------------------------------------
// bandpass_envelope_filter_q15: Q15 band-pass FIR, rectifier and low-pass FIR
// One shared multiply-accumulate unit runs both filters under a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                      Width  Direction
//  input     in_valid, in_ready, sample   16     in  (signed sample)
//  output    out_valid, out_ready, envelope 16   out (signed envelope)
//
// After a sample is accepted, the envelope is loaded into the output
// register after 30 band-pass MACs and 33 low-pass MACs on the single
// 16x16 multiplier, each filter followed by a drain and a finish state.
// in_ready is high only while the sequencer is idle. A result that waits in
// the output register holds the next sample at its final cycle.
// Reset clears both delay lines and the sequencer at once.
//
`default_nettype none

module bandpass_envelope_filter_q15 #(
	parameter int BAND_TAPS   = bef_pkg::BAND_TAPS,
	parameter int SMOOTH_TAPS = bef_pkg::SMOOTH_TAPS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [bef_pkg::DATA_W-1:0]  sample,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [bef_pkg::DATA_W-1:0]       envelope
);

	localparam int DW = bef_pkg::DATA_W;
	localparam int AW = bef_pkg::ACC_W;
	localparam int KW = bef_pkg::IDX_W;

	bef_pkg::state_t state_q, state_d;

	// Both delay lines are circular shift lines: the MAC always reads tap 0,
	// and a full pass of rotations brings each line back to its place.
	logic signed [DW-1:0] band_q   [BAND_TAPS];
	logic signed [DW-1:0] smooth_q [SMOOTH_TAPS];

	logic [KW-1:0]        cnt_q;
	logic signed [AW-1:0] prod_q;
	logic                 prod_vld_q;
	logic signed [AW-1:0] acc_q;
	logic                 out_vld_q;
	logic signed [DW-1:0] env_q;

	logic accept;
	logic band_run, smooth_run, band_fin, load_out, cnt_last_band, cnt_last_smooth;
	logic signed [DW-1:0]     band_val;
	logic signed [DW-1:0]     band_abs;
	logic signed [DW-1:0]     mul_a;
	logic signed [bef_pkg::COEF_W-1:0] mul_b;

	assign in_ready        = (state_q == bef_pkg::ST_IDLE);
	assign accept          = in_valid && in_ready;
	assign cnt_last_band   = (cnt_q == KW'(BAND_TAPS - 1));
	assign cnt_last_smooth = (cnt_q == KW'(SMOOTH_TAPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bef_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		band_run   = 1'b0;
		smooth_run = 1'b0;
		band_fin   = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			bef_pkg::ST_IDLE: begin
				if (in_valid) state_d = bef_pkg::ST_BAND;
			end
			bef_pkg::ST_BAND: begin
				band_run = 1'b1;
				if (cnt_last_band) state_d = bef_pkg::ST_BAND_DRAIN;
			end
			bef_pkg::ST_BAND_DRAIN: begin
				state_d = bef_pkg::ST_BAND_FIN;
			end
			bef_pkg::ST_BAND_FIN: begin
				band_fin = 1'b1;
				state_d  = bef_pkg::ST_SMOOTH;
			end
			bef_pkg::ST_SMOOTH: begin
				smooth_run = 1'b1;
				if (cnt_last_smooth) state_d = bef_pkg::ST_SMOOTH_DRAIN;
			end
			bef_pkg::ST_SMOOTH_DRAIN: begin
				state_d = bef_pkg::ST_SMOOTH_FIN;
			end
			bef_pkg::ST_SMOOTH_FIN: begin
				if (!out_vld_q || out_ready) begin
					load_out = 1'b1;
					state_d  = bef_pkg::ST_IDLE;
				end
			end
			default: state_d = bef_pkg::ST_IDLE;
		endcase
	end

	// Floor shift by 15 then wrap to 16 bits is simply bits 30:15.
	assign band_val = acc_q[DW+14:15];
	assign band_abs = (band_val == {1'b1, {(DW-1){1'b0}}}) ? {1'b0, {(DW-1){1'b1}}}
	                : (band_val[DW-1] ? -band_val : band_val);

	assign mul_a = band_run ? band_q[0] : smooth_q[0];
	assign mul_b = band_run ? bef_pkg::band_coef(cnt_q) : bef_pkg::smooth_coef(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_TAPS; i++) band_q[i] <= '0;
		end else if (accept) begin
			band_q[0] <= sample;
			for (int i = 1; i < BAND_TAPS; i++) band_q[i] <= band_q[i-1];
		end else if (band_run) begin
			band_q[BAND_TAPS-1] <= band_q[0];
			for (int i = 0; i < BAND_TAPS - 1; i++) band_q[i] <= band_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_TAPS; i++) smooth_q[i] <= '0;
		end else if (band_fin) begin
			smooth_q[0] <= band_abs;
			for (int i = 1; i < SMOOTH_TAPS; i++) smooth_q[i] <= smooth_q[i-1];
		end else if (smooth_run) begin
			smooth_q[SMOOTH_TAPS-1] <= smooth_q[0];
			for (int i = 0; i < SMOOTH_TAPS - 1; i++) smooth_q[i] <= smooth_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			prod_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if ((band_run && cnt_last_band) || (smooth_run && cnt_last_smooth)) begin
				cnt_q <= '0;
			end else if (band_run || smooth_run) begin
				cnt_q <= cnt_q + KW'(1);
			end
			prod_vld_q <= band_run || smooth_run;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// The product is registered; the accumulator adds it in the next cycle.
	always_ff @(posedge clk) begin
		prod_q <= AW'(mul_a * mul_b);
		if (accept || band_fin) begin
			acc_q <= bef_pkg::ROUND_BIAS;
		end else if (prod_vld_q) begin
			acc_q <= acc_q + prod_q;
		end
		if (load_out) begin
			env_q <= acc_q[DW+14:15];
		end
	end

	assign out_valid = out_vld_q;
	assign envelope  = env_q;

endmodule

`default_nettype wire

FILE: hdl/bef_checker.sv
// ----------------------------------------------------------------------------
// bef_checker: port-level checks for the band-pass envelope filter
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module bef_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic signed [bef_pkg::DATA_W-1:0]  sample,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [bef_pkg::DATA_W-1:0]  envelope
);

	// A sample beat starts a long computation, so ready must drop.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after a sample beat");

	// Ready only falls because a sample beat was taken.
	a_ready_falls_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready fell without a sample beat");

	// The sequencer returns to idle as the envelope is presented.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("envelope presented while still busy");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("waiting sample beat changed or dropped");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(envelope))
		else $error("stalled envelope beat changed or dropped");

endmodule

bind bandpass_envelope_filter_q15 bef_checker u_bef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.sample    (sample),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.envelope  (envelope)
);

`default_nettype wire
